@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the stepper position sequencer.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define SPS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sps assertion failed");
// Check that a condition in one cycle implies a consequence in the same cycle.
`define SPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  `SPS_ASSERT(label, clk, rst, (ante) |-> (cons))
`else
`define SPS_ASSERT(label, clk, rst, prop)
`define SPS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sps_pkg.sv @@
// Package for the stepper position sequencer: word types, codes, defaults.
// No dependencies; used by every module of the block but sps_ram.
`default_nettype none

package sps_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 8;
  localparam int POS_W = 32;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_HOME = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_BACK = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [POS_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] target;
    logic [1:0]              motor_mode;
    logic [1:0]              step_taken;
    logic [1:0]              status;
    logic [3:0]              queued_moves;
  } out_word_t;

  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [POS_W-1:0] data;
  } queue_ctrl_t;

  typedef struct packed {
    logic                    empty;
    logic                    full;
    logic signed [POS_W-1:0] head;
  } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/sps_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/sps_move_queue.sv @@
// FIFO of queued relative moves with the head word always presented.
// Depends on sps_pkg and sps_ram.
`default_nettype none

module sps_move_queue #(
  parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sps_pkg::queue_ctrl_t  ctrl,
  output sps_pkg::queue_status_t     status,
  output logic [3:0]                 level_next
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [AW-1:0] read_slot;
  logic [AW-1:0] read_slot_next;
  logic [AW-1:0] write_slot;
  logic [AW-1:0] write_slot_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          bypass_hit;
  logic [sps_pkg::POS_W-1:0] bypass_data;
  logic [sps_pkg::POS_W-1:0] ram_rdata;

  // wrap at the last slot
  always_comb begin
    read_slot_next  = read_slot;
    write_slot_next = write_slot;
    if (ctrl.pop) begin
      read_slot_next = (read_slot == AW'(QUEUE_DEPTH - 1)) ? '0 : read_slot + AW'(1);
    end
    if (ctrl.push) begin
      write_slot_next = (write_slot == AW'(QUEUE_DEPTH - 1)) ? '0 : write_slot + AW'(1);
    end
    unique case ({ctrl.push, ctrl.pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_slot  <= '0;
      write_slot <= '0;
      count      <= '0;
      bypass_hit <= 1'b0;
    end else begin
      read_slot  <= read_slot_next;
      write_slot <= write_slot_next;
      count      <= count_next;
      // a word written to the slot being fetched is forwarded next cycle
      bypass_hit <= ctrl.push && (write_slot == read_slot_next);
    end
    bypass_data <= ctrl.data;
  end

  sps_ram #(
    .WIDTH (sps_pkg::POS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (write_slot),
    .wdata (ctrl.data),
    .raddr (read_slot_next),
    .rdata (ram_rdata)
  );

  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.head  = bypass_hit ? bypass_data : ram_rdata;
  assign level_next   = 4'(count_next);

endmodule

`default_nettype wire

@@ rtl/sps_motion_core.sv @@
// Position, target and mode registers with the per-command update logic.
// Depends on sps_pkg.
`default_nettype none

module sps_motion_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire sps_pkg::in_word_t      word,
  input  wire sps_pkg::queue_status_t qstat,
  input  wire logic [3:0]             level_next,
  output sps_pkg::queue_ctrl_t        qctrl,
  output sps_pkg::out_word_t          result_next
);

  logic signed [sps_pkg::POS_W-1:0] position;
  logic signed [sps_pkg::POS_W-1:0] position_next;
  logic signed [sps_pkg::POS_W-1:0] goal;
  logic signed [sps_pkg::POS_W-1:0] goal_next;
  logic signed [sps_pkg::POS_W-1:0] goal_tick;
  logic signed [sps_pkg::POS_W-1:0] goal_sat;
  logic signed [sps_pkg::POS_W:0]   wide_sum;
  logic [1:0] mode;
  logic [1:0] mode_next;
  logic [1:0] mode_tick;
  logic [1:0] step;
  logic [1:0] status;
  logic       push;
  logic       pop;

  // saturate the new target to the 32-bit range
  assign wide_sum = {goal[sps_pkg::POS_W-1], goal} + {qstat.head[sps_pkg::POS_W-1], qstat.head};
  assign goal_sat = (wide_sum[sps_pkg::POS_W] != wide_sum[sps_pkg::POS_W-1]) ?
                    (wide_sum[sps_pkg::POS_W] ? {1'b1, {(sps_pkg::POS_W-1){1'b0}}}
                                              : {1'b0, {(sps_pkg::POS_W-1){1'b1}}}) :
                    wide_sum[sps_pkg::POS_W-1:0];

  always_comb begin
    position_next = position;
    goal_next     = goal;
    mode_next     = mode;
    goal_tick     = goal;
    mode_tick     = mode;
    step          = sps_pkg::STEP_NONE;
    status        = sps_pkg::STATUS_OK;
    push          = 1'b0;
    pop           = 1'b0;
    if (mode == sps_pkg::MODE_STOP && word.cmd != sps_pkg::CMD_HOME) begin
      status = sps_pkg::STATUS_IGNORED;
    end else begin
      unique case (word.cmd)
        sps_pkg::CMD_MOVE: begin
          if (qstat.full) begin
            status = sps_pkg::STATUS_FULL;
          end else begin
            push = 1'b1;
          end
        end
        sps_pkg::CMD_HOME: begin
          position_next = word.payload;
          goal_next     = word.payload;
          mode_next     = sps_pkg::MODE_IDLE;
        end
        sps_pkg::CMD_STOP: begin
          mode_next = sps_pkg::MODE_STOP;
        end
        sps_pkg::CMD_TICK: begin
          if (mode == sps_pkg::MODE_IDLE && !qstat.empty) begin
            goal_tick = goal_sat;
            mode_tick = sps_pkg::MODE_RUN;
            pop       = 1'b1;
          end
          goal_next = goal_tick;
          mode_next = mode_tick;
          if (mode_tick == sps_pkg::MODE_RUN) begin
            if (position < goal_tick) begin
              position_next = position + 32'sd1;
              step          = sps_pkg::STEP_FWD;
            end else if (position > goal_tick) begin
              position_next = position - 32'sd1;
              step          = sps_pkg::STEP_BACK;
            end
            if (position_next == goal_tick) begin
              mode_next = sps_pkg::MODE_IDLE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      goal     <= '0;
      mode     <= sps_pkg::MODE_IDLE;
    end else if (advance) begin
      position <= position_next;
      goal     <= goal_next;
      mode     <= mode_next;
    end
  end

  assign qctrl.push = push && advance;
  assign qctrl.pop  = pop && advance;
  assign qctrl.data = word.payload;

  assign result_next.position     = position_next;
  assign result_next.target       = goal_next;
  assign result_next.motor_mode   = mode_next;
  assign result_next.step_taken   = step;
  assign result_next.status       = status;
  assign result_next.queued_moves = level_next;

endmodule

`default_nettype wire

@@ rtl/stepper_position_sequencer.sv @@
// Top level of the stepper position sequencer: handshake registers and checks.
// Depends on sps_pkg, sps_move_queue, sps_motion_core and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

//  channel   direction  handshake                  word type
//  command   in         command_valid/_stall       sps_pkg::in_word_t
//  result    out        result_valid/_stall        sps_pkg::out_word_t
//
//  Every command word gives exactly one result word: once it is taken, the
//  word sits in the command register while the update logic works out its
//  result, which lands in the result register when the update advances.
//  One word a cycle is sustained while results are taken; the
//  registered read of the move store keeps the next head ready every cycle.
//  Reset (rst, synchronous) empties the queue and sets position and target to
//  zero, mode idle. A stalled result holds the update; command_stall rises
//  only while a command word is held behind a stalled result word.

module stepper_position_sequencer #(
  parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               command_valid,
  output logic                    command_stall,
  input  wire sps_pkg::in_word_t  command,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output sps_pkg::out_word_t      result
);

  // command register
  logic                   held_valid;
  sps_pkg::in_word_t      held;
  // update strobe: the held word is processed and its result registered
  logic                   advance;
  sps_pkg::queue_ctrl_t   qctrl;
  sps_pkg::queue_status_t qstat;
  logic [3:0]             level_next;
  sps_pkg::out_word_t     result_next;

  // advance whenever a word is held and the result register is free or being emptied
  assign advance       = held_valid && (!result_valid || !result_stall);
  assign command_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!command_stall) begin
      held_valid <= command_valid;
    end
    if (!command_stall && command_valid) begin
      held <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  sps_move_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (qctrl),
    .status     (qstat),
    .level_next (level_next)
  );

  sps_motion_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .word        (held),
    .qstat       (qstat),
    .level_next  (level_next),
    .qctrl       (qctrl),
    .result_next (result_next)
  );

  // an idle motor sits on its target, a running one does not
  `SPS_ASSERT_IMPLY(a_idle_on_target, clk, rst, result_valid && result.motor_mode == sps_pkg::MODE_IDLE, result.position == result.target)
  `SPS_ASSERT_IMPLY(a_run_off_target, clk, rst, result_valid && result.motor_mode == sps_pkg::MODE_RUN, result.position != result.target)
  // ignored words come only from a stopped motor and never step
  `SPS_ASSERT_IMPLY(a_ignored_stopped, clk, rst, result_valid && result.status == sps_pkg::STATUS_IGNORED, result.motor_mode == sps_pkg::MODE_STOP && result.step_taken == sps_pkg::STEP_NONE)
  // every processed word lands in the result register
  `SPS_ASSERT(a_advance_lands, clk, rst, advance |=> result_valid)

endmodule

`default_nettype wire
